/* rtl/ltrbs_pkg.sv */
// ----------------------------------------------------------------------------
// ltrbs_pkg
// Shared types, constants and helpers for the luma row band segmenter.
// ----------------------------------------------------------------------------
package ltrbs_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned SIZE_W = 13;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned LUMA_W = 15;

  localparam logic [SIZE_W-1:0] SIZE_MIN  = 13'd3;
  localparam logic [SIZE_W-1:0] WIDTH_HI  =
    SIZE_W'((MAX_WIDTH < 4096) ? ((MAX_WIDTH < 3) ? 3 : MAX_WIDTH) : 4096);
  localparam logic [SIZE_W-1:0] HEIGHT_HI =
    SIZE_W'((MAX_HEIGHT < 4096) ? ((MAX_HEIGHT < 3) ? 3 : MAX_HEIGHT) : 4096);

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [7:0]        THRESH_RST = 8'd127;

  localparam logic [LUMA_W-1:0] LUMA_KR   = 15'd30;
  localparam logic [LUMA_W-1:0] LUMA_KG   = 15'd59;
  localparam logic [LUMA_W-1:0] LUMA_KB   = 15'd11;
  localparam logic [LUMA_W-1:0] THRESH_K  = 15'd100;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_DARK_THRESHOLD = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } ltrbs_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] band_top;
    logic [ROW_W-1:0] band_bottom;
  } ltrbs_out_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    if (v < SIZE_MIN) begin
      res = SIZE_MIN;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

/* rtl/luma_threshold_row_band_segmenter_unit.sv */
// ----------------------------------------------------------------------------
// luma_threshold_row_band_segmenter_unit
// Thresholds RGB pixels on luma, tracks dark rows and emits text row bands.
// ----------------------------------------------------------------------------
// Output: a band reaches out_valid after the last pixel of the empty row that closes it
//   passes the pixel register and then the result register; an output stall can hold it.
// Throughput: one pixel per cycle unless a pending result is stalled by out_ready; the
//   luma compare and counter update sit in one stage between the pixel and result registers.
// Reset: synchronous, active low; clears counters, row flags and valid bits,
//   and loads width 640, height 480, threshold 127.
module luma_threshold_row_band_segmenter_unit
  import ltrbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ltrbs_in_t         in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ltrbs_out_t        out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [7:0]        thresh_r;

  logic              pix_valid_r;
  ltrbs_in_t         pix_r;

  logic [ROW_W-1:0]  col_r,       col_nxt;
  logic [ROW_W-1:0]  row_r,       row_nxt;
  logic              cur_dark_r,  cur_dark_nxt;
  logic              prev_dark_r, prev_dark_nxt;
  logic [ROW_W-1:0]  start_r,     start_nxt;

  logic              out_valid_r;
  ltrbs_out_t        out_r;

  logic              advance;
  logic              emit;
  logic [SIZE_W-1:0] eff_w;
  logic [SIZE_W-1:0] eff_h;
  logic [SIZE_W-1:0] col_inc;
  logic [SIZE_W-1:0] row_inc;
  logic              col_last;
  logic              row_last;
  logic              border;
  logic [LUMA_W-1:0] luma100;
  logic [LUMA_W-1:0] thresh100;
  logic              pix_dark;
  logic              row_dark;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH:    width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT:   height_r <= cfg_wdata;
        CFG_DARK_THRESHOLD: thresh_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign advance  = pix_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !pix_valid_r || advance;

  // pixel register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (in_ready) begin
      pix_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pix_r <= in_data;
    end
  end

  // classify and advance counters
  always_comb begin
    eff_w     = clamp_size(width_r, WIDTH_HI);
    eff_h     = clamp_size(height_r, HEIGHT_HI);
    col_inc   = {1'b0, col_r} + 13'd1;
    row_inc   = {1'b0, row_r} + 13'd1;
    col_last  = col_inc >= eff_w;
    row_last  = row_inc >= eff_h;
    border    = (col_r == '0) || col_last || (row_r == '0) || row_last;
    luma100   = LUMA_W'(pix_r.red) * LUMA_KR + LUMA_W'(pix_r.green) * LUMA_KG
              + LUMA_W'(pix_r.blue) * LUMA_KB;
    thresh100 = LUMA_W'(thresh_r) * THRESH_K;
    pix_dark  = !border && (luma100 < thresh100);
    row_dark  = cur_dark_r || pix_dark;

    col_nxt       = col_inc[ROW_W-1:0];
    row_nxt       = row_r;
    cur_dark_nxt  = row_dark;
    prev_dark_nxt = prev_dark_r;
    start_nxt     = start_r;
    emit          = 1'b0;

    if (col_last) begin
      if (row_dark && !prev_dark_r) begin
        start_nxt = row_r - 12'd1;
      end
      emit          = !row_dark && prev_dark_r;
      prev_dark_nxt = row_dark;
      cur_dark_nxt  = 1'b0;
      col_nxt       = '0;
      if (row_last) begin
        row_nxt       = '0;
        prev_dark_nxt = 1'b0;
      end else begin
        row_nxt = row_inc[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      cur_dark_r  <= 1'b0;
      prev_dark_r <= 1'b0;
      start_r     <= '0;
    end else if (advance) begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cur_dark_r  <= cur_dark_nxt;
      prev_dark_r <= prev_dark_nxt;
      start_r     <= start_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_r.band_top    <= start_r;
      out_r.band_bottom <= row_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (pix_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");

  a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !advance) |=> !out_valid_r)
    else $error("result held after its transfer");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && col_last && row_last) |=> (!prev_dark_r && row_r == '0 && col_r == '0))
    else $error("frame end did not clear row state");
`endif

endmodule
